[rtl/lsmc_pkg.sv]
// Package for the status LED mode controller.
// Holds the event and command codes, the controller state and result types.
// No dependencies.
`default_nettype none

package lsmc_pkg;

    localparam int REQ_W     = 4;
    localparam int NOW_W     = 32;
    localparam int QUAL_W    = 8;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 16;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 16;

    localparam logic [REQ_W-1:0] REQ_SOFT_RESET  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_FATAL       = 4'd1;
    localparam logic [REQ_W-1:0] REQ_LINK_QUAL   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_DIAG_UNAVAIL = 4'd3;
    localparam logic [REQ_W-1:0] REQ_BIND        = 4'd4;
    localparam logic [REQ_W-1:0] REQ_WIFI        = 4'd5;
    localparam logic [REQ_W-1:0] REQ_MAINT_RESET = 4'd6;
    localparam logic [REQ_W-1:0] REQ_CLEAR_MAINT = 4'd7;
    localparam logic [REQ_W-1:0] REQ_UPDATE      = 4'd8;

    localparam logic [STATUS_W-1:0] STATUS_ERROR    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RX_LOST  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FRAMES   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BYTES    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_READY    = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_STARTUP  = 3'd5;

    localparam logic CFG_DIAG_HOLD    = 1'b0;
    localparam logic CFG_BLINK_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] DIAG_HOLD_RESET    = 16'd3000;
    localparam logic [CFG_W-1:0] BLINK_PERIOD_RESET = 16'd250;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DIAG   = 2'd1,
        MODE_MAINT  = 2'd2,
        MODE_FATAL  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PRES_NONE  = 2'd0,
        PRES_BIND  = 2'd1,
        PRES_WIFI  = 2'd2,
        PRES_RESET = 2'd3
    } pres_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_STATUS  = 3'd0,
        CMD_LQ      = 3'd1,
        CMD_UNAVAIL = 3'd2,
        CMD_BIND    = 3'd3,
        CMD_WIFI    = 3'd4,
        CMD_RED     = 3'd5,
        CMD_OFF     = 3'd6
    } cmd_t;

    typedef struct packed {
        mode_t                mode;
        pres_t                pres;
        logic [NOW_W-1:0]     diag_start;
        logic [NOW_W-1:0]     blink_last;
        logic                 blink_started;
        logic                 blink_on;
        logic                 normal_shown;
        logic [STATUS_W-1:0]  last_status;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:          MODE_NORMAL,
        pres:          PRES_NONE,
        diag_start:    '0,
        blink_last:    '0,
        blink_started: 1'b0,
        blink_on:      1'b0,
        normal_shown:  1'b0,
        last_status:   STATUS_STARTUP
    };

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [NOW_W-1:0]  now;
        logic [QUAL_W-1:0] quality;
        logic              lost;
        logic              frames;
        logic              bytes_seen;
    } item_t;

    typedef struct packed {
        logic                valid;
        cmd_t                cmd;
        logic [STATUS_W-1:0] code;
        logic [QUAL_W-1:0]   quality;
    } result_t;

endpackage

`default_nettype wire

[rtl/lsmc_step.sv]
// Next-state and command logic for one event of the status LED mode controller.
// Depends on lsmc_pkg.
`default_nettype none

module lsmc_step (
    input  lsmc_pkg::state_t            cur,
    input  lsmc_pkg::item_t             item,
    input  logic [lsmc_pkg::CFG_W-1:0]  diag_hold,
    input  logic [lsmc_pkg::CFG_W-1:0]  blink_period,
    output lsmc_pkg::state_t            nxt,
    output lsmc_pkg::result_t           res
);

    logic [lsmc_pkg::NOW_W-1:0]    diag_elapsed;
    logic [lsmc_pkg::NOW_W-1:0]    blink_elapsed;
    logic                          diag_expired;
    logic                          blink_due;
    logic                          leave_diag;
    logic                          shown;
    logic [lsmc_pkg::STATUS_W-1:0] want;

    assign diag_elapsed  = item.now - cur.diag_start;
    assign blink_elapsed = item.now - cur.blink_last;
    assign diag_expired  = diag_elapsed >= {{(lsmc_pkg::NOW_W-lsmc_pkg::CFG_W){1'b0}}, diag_hold};
    assign blink_due     = blink_elapsed
                           >= {{(lsmc_pkg::NOW_W-lsmc_pkg::CFG_W){1'b0}}, blink_period};
    assign leave_diag    = (cur.mode == lsmc_pkg::MODE_DIAG) && (item.lost || diag_expired);
    assign shown         = leave_diag ? 1'b0 : cur.normal_shown;

    always_comb
    begin
        if (item.lost)
            want = lsmc_pkg::STATUS_RX_LOST;
        else if (item.frames)
            want = lsmc_pkg::STATUS_FRAMES;
        else if (item.bytes_seen)
            want = lsmc_pkg::STATUS_BYTES;
        else
            want = lsmc_pkg::STATUS_READY;
    end

    always_comb
    begin
        nxt         = cur;
        res.valid   = 1'b0;
        res.cmd     = lsmc_pkg::CMD_STATUS;
        res.code    = '0;
        res.quality = '0;
        case (item.req)
            lsmc_pkg::REQ_SOFT_RESET:
            begin
                nxt = lsmc_pkg::STATE_RESET;
            end
            lsmc_pkg::REQ_FATAL:
            begin
                nxt.mode  = lsmc_pkg::MODE_FATAL;
                nxt.pres  = lsmc_pkg::PRES_NONE;
                res.valid = 1'b1;
                res.code  = lsmc_pkg::STATUS_ERROR;
            end
            default:
            begin
                if (cur.mode != lsmc_pkg::MODE_FATAL)
                begin
                    case (item.req)
                        lsmc_pkg::REQ_LINK_QUAL,
                        lsmc_pkg::REQ_DIAG_UNAVAIL:
                        begin
                            nxt.mode       = lsmc_pkg::MODE_DIAG;
                            nxt.pres       = lsmc_pkg::PRES_NONE;
                            nxt.diag_start = item.now;
                            res.valid      = 1'b1;
                            if (item.req == lsmc_pkg::REQ_LINK_QUAL)
                            begin
                                res.cmd     = lsmc_pkg::CMD_LQ;
                                res.quality = item.quality;
                            end
                            else
                            begin
                                res.cmd = lsmc_pkg::CMD_UNAVAIL;
                            end
                        end
                        lsmc_pkg::REQ_BIND:
                        begin
                            nxt.mode          = lsmc_pkg::MODE_MAINT;
                            nxt.pres          = lsmc_pkg::PRES_BIND;
                            nxt.blink_started = 1'b0;
                            nxt.blink_on      = 1'b0;
                            res.valid         = 1'b1;
                            res.cmd           = lsmc_pkg::CMD_BIND;
                        end
                        lsmc_pkg::REQ_WIFI:
                        begin
                            nxt.mode          = lsmc_pkg::MODE_MAINT;
                            nxt.pres          = lsmc_pkg::PRES_WIFI;
                            nxt.blink_started = 1'b0;
                            nxt.blink_on      = 1'b0;
                            res.valid         = 1'b1;
                            res.cmd           = lsmc_pkg::CMD_WIFI;
                        end
                        lsmc_pkg::REQ_MAINT_RESET:
                        begin
                            nxt.mode          = lsmc_pkg::MODE_MAINT;
                            nxt.pres          = lsmc_pkg::PRES_RESET;
                            nxt.blink_started = 1'b0;
                            nxt.blink_on      = 1'b1;
                            res.valid         = 1'b1;
                            res.cmd           = lsmc_pkg::CMD_RED;
                        end
                        lsmc_pkg::REQ_CLEAR_MAINT:
                        begin
                            if (cur.mode == lsmc_pkg::MODE_MAINT)
                            begin
                                nxt.mode          = lsmc_pkg::MODE_NORMAL;
                                nxt.pres          = lsmc_pkg::PRES_NONE;
                                nxt.blink_started = 1'b0;
                                nxt.blink_on      = 1'b0;
                                nxt.normal_shown  = 1'b0;
                            end
                        end
                        lsmc_pkg::REQ_UPDATE:
                        begin
                            if (cur.mode == lsmc_pkg::MODE_MAINT)
                            begin
                                if (cur.pres == lsmc_pkg::PRES_RESET)
                                begin
                                    if (!cur.blink_started)
                                    begin
                                        nxt.blink_last    = item.now;
                                        nxt.blink_started = 1'b1;
                                    end
                                    else if (blink_due)
                                    begin
                                        nxt.blink_last = item.now;
                                        nxt.blink_on   = !cur.blink_on;
                                        res.valid      = 1'b1;
                                        res.cmd        = cur.blink_on ? lsmc_pkg::CMD_OFF
                                                                      : lsmc_pkg::CMD_RED;
                                    end
                                end
                            end
                            else if (cur.mode != lsmc_pkg::MODE_DIAG || leave_diag)
                            begin
                                nxt.mode         = lsmc_pkg::MODE_NORMAL;
                                nxt.normal_shown = shown;
                                if (!(shown && want == cur.last_status))
                                begin
                                    nxt.last_status  = want;
                                    nxt.normal_shown = 1'b1;
                                    res.valid        = 1'b1;
                                    res.code         = want;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/led_status_mode_controller.sv]
// Top level of the status LED mode controller: stream ports, registers, config.
// Depends on lsmc_pkg and lsmc_step.
// One event is accepted every cycle unless a stalled result holds a full input
// register. An event is held in an input register, its command and the updated
// mode state are computed combinationally from that register and the command
// lands in the result register. Events that give no command leave no
// result. A stalled result blocks only once the input register is also full.
`default_nettype none

module led_status_mode_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [lsmc_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] now_ms, [39:32] link_quality, [40] receiver_lost,
    // [41] has_rc_frames, [42] has_receiver_bytes, [47:43] zero
    input  wire logic [lsmc_pkg::S_DATA_W-1:0]   s_tdata,
    // [3:0] req_type
    input  wire logic [lsmc_pkg::REQ_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] status_code, [10:3] shown_quality, [15:11] zero
    output logic [lsmc_pkg::M_DATA_W-1:0]        m_tdata,
    // [2:0] led_command
    output logic [lsmc_pkg::CMD_W-1:0]           m_tuser
);

    logic                            in_valid_reg;
    lsmc_pkg::item_t                 item_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    lsmc_pkg::result_t               result_reg;
    lsmc_pkg::state_t                state_reg;
    lsmc_pkg::state_t                state_next;
    lsmc_pkg::result_t               step_res;
    logic [lsmc_pkg::CFG_W-1:0]      diag_hold_reg;
    logic [lsmc_pkg::CFG_W-1:0]      blink_period_reg;
    logic                            advance;
    logic                            in_take;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;

    lsmc_step u_step (
        .cur          (state_reg),
        .item         (item_reg),
        .diag_hold    (diag_hold_reg),
        .blink_period (blink_period_reg),
        .nxt          (state_next),
        .res          (step_res)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = step_res.valid;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg        <= lsmc_pkg::STATE_RESET;
            diag_hold_reg    <= lsmc_pkg::DIAG_HOLD_RESET;
            blink_period_reg <= lsmc_pkg::BLINK_PERIOD_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lsmc_pkg::CFG_DIAG_HOLD)
                    diag_hold_reg <= cfg_data;
                else
                    blink_period_reg <= cfg_data;
            end
        end
    end

    // Payload: hold on stall
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req        <= s_tuser;
            item_reg.now        <= s_tdata[31:0];
            item_reg.quality    <= s_tdata[39:32];
            item_reg.lost       <= s_tdata[40];
            item_reg.frames     <= s_tdata[41];
            item_reg.bytes_seen <= s_tdata[42];
        end
        if (advance && step_res.valid)
            result_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.cmd;
    assign m_tdata  = {5'd0, result_reg.quality, result_reg.code};

endmodule

`default_nettype wire

[bench/led_status_mode_controller_tb.sv]
// Self-checking bench for led_status_mode_controller: directed and random event streams,
// predicted LED commands checked transfer by transfer.
// Depends on lsmc_pkg and the led_status_mode_controller RTL.
`timescale 1ns / 1ps

module led_status_mode_controller_tb;

    localparam int REQ_CODES = 16;

    typedef struct packed {
        lsmc_pkg::cmd_t                cmd;
        logic [lsmc_pkg::STATUS_W-1:0] code;
        logic [lsmc_pkg::QUAL_W-1:0]   quality;
    } led_cmd_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index = lsmc_pkg::CFG_DIAG_HOLD;
    logic [lsmc_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [lsmc_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [lsmc_pkg::REQ_W-1:0]    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lsmc_pkg::M_DATA_W-1:0] m_tdata;
    logic [lsmc_pkg::CMD_W-1:0]    m_tuser;

    lsmc_pkg::item_t pending_events[$];
    led_cmd_t        led_cmds_due[$];
    lsmc_pkg::item_t offered;
    led_cmd_t        head;

    // controller image
    lsmc_pkg::mode_t               disp_mode;
    lsmc_pkg::pres_t               disp_pres;
    logic [lsmc_pkg::NOW_W-1:0]    diag_from;
    logic [lsmc_pkg::NOW_W-1:0]    blink_mark;
    logic                          blink_armed;
    logic                          blink_lit;
    logic                          status_valid;
    logic [lsmc_pkg::STATUS_W-1:0] status_shown;
    logic [lsmc_pkg::CFG_W-1:0]    hold_ms_reg = lsmc_pkg::DIAG_HOLD_RESET;
    logic [lsmc_pkg::CFG_W-1:0]    blink_ms_reg = lsmc_pkg::BLINK_PERIOD_RESET;

    int          pushed_total = 0;
    int          useful_count = 0;
    int          items_taken;
    int          bad_transfers = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cnt;
    int          holds_done;
    int          step_max = 4;
    logic [31:0] ms_now = '0;

    led_status_mode_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    task automatic clear_led_state();
        disp_mode    = lsmc_pkg::MODE_NORMAL;
        disp_pres    = lsmc_pkg::PRES_NONE;
        diag_from    = '0;
        blink_mark   = '0;
        blink_armed  = 1'b0;
        blink_lit    = 1'b0;
        status_valid = 1'b0;
        status_shown = lsmc_pkg::STATUS_STARTUP;
    endtask

    task automatic derive_led_cmd(input lsmc_pkg::item_t ev);
        led_cmd_t                      r;
        logic                          fire;
        logic                          show;
        logic [lsmc_pkg::STATUS_W-1:0] want;
        logic [lsmc_pkg::NOW_W-1:0]    elapsed;
        r    = '{cmd: lsmc_pkg::CMD_STATUS, code: '0, quality: '0};
        fire = 1'b0;
        if (ev.req == lsmc_pkg::REQ_SOFT_RESET)
        begin
            clear_led_state();
        end
        else if (ev.req == lsmc_pkg::REQ_FATAL)
        begin
            disp_mode = lsmc_pkg::MODE_FATAL;
            disp_pres = lsmc_pkg::PRES_NONE;
            r.code    = lsmc_pkg::STATUS_ERROR;
            fire      = 1'b1;
        end
        else if (ev.req <= lsmc_pkg::REQ_UPDATE && disp_mode != lsmc_pkg::MODE_FATAL)
        begin
            case (ev.req)
                lsmc_pkg::REQ_LINK_QUAL, lsmc_pkg::REQ_DIAG_UNAVAIL:
                begin
                    disp_mode = lsmc_pkg::MODE_DIAG;
                    disp_pres = lsmc_pkg::PRES_NONE;
                    diag_from = ev.now;
                    fire      = 1'b1;
                    if (ev.req == lsmc_pkg::REQ_LINK_QUAL)
                    begin
                        r.cmd     = lsmc_pkg::CMD_LQ;
                        r.quality = ev.quality;
                    end
                    else
                    begin
                        r.cmd = lsmc_pkg::CMD_UNAVAIL;
                    end
                end
                lsmc_pkg::REQ_BIND, lsmc_pkg::REQ_WIFI, lsmc_pkg::REQ_MAINT_RESET:
                begin
                    disp_mode   = lsmc_pkg::MODE_MAINT;
                    blink_armed = 1'b0;
                    fire        = 1'b1;
                    if (ev.req == lsmc_pkg::REQ_BIND)
                    begin
                        disp_pres = lsmc_pkg::PRES_BIND;
                        r.cmd     = lsmc_pkg::CMD_BIND;
                    end
                    else if (ev.req == lsmc_pkg::REQ_WIFI)
                    begin
                        disp_pres = lsmc_pkg::PRES_WIFI;
                        r.cmd     = lsmc_pkg::CMD_WIFI;
                    end
                    else
                    begin
                        disp_pres = lsmc_pkg::PRES_RESET;
                        r.cmd     = lsmc_pkg::CMD_RED;
                    end
                    blink_lit = (disp_pres == lsmc_pkg::PRES_RESET);
                end
                lsmc_pkg::REQ_CLEAR_MAINT:
                begin
                    if (disp_mode == lsmc_pkg::MODE_MAINT)
                    begin
                        disp_mode    = lsmc_pkg::MODE_NORMAL;
                        disp_pres    = lsmc_pkg::PRES_NONE;
                        blink_armed  = 1'b0;
                        blink_lit    = 1'b0;
                        status_valid = 1'b0;
                    end
                end
                default:
                begin
                    if (disp_mode == lsmc_pkg::MODE_MAINT)
                    begin
                        if (disp_pres == lsmc_pkg::PRES_RESET)
                        begin
                            elapsed = ev.now - blink_mark;
                            if (!blink_armed)
                            begin
                                blink_mark  = ev.now;
                                blink_armed = 1'b1;
                            end
                            else if (elapsed >= {16'd0, blink_ms_reg})
                            begin
                                blink_mark = ev.now;
                                blink_lit  = ~blink_lit;
                                r.cmd      = blink_lit ? lsmc_pkg::CMD_RED : lsmc_pkg::CMD_OFF;
                                fire       = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        show    = 1'b1;
                        elapsed = ev.now - diag_from;
                        if (disp_mode == lsmc_pkg::MODE_DIAG)
                        begin
                            if (ev.lost || elapsed >= {16'd0, hold_ms_reg})
                            begin
                                disp_mode    = lsmc_pkg::MODE_NORMAL;
                                status_valid = 1'b0;
                            end
                            else
                            begin
                                show = 1'b0;
                            end
                        end
                        if (ev.lost)
                            want = lsmc_pkg::STATUS_RX_LOST;
                        else if (ev.frames)
                            want = lsmc_pkg::STATUS_FRAMES;
                        else if (ev.bytes_seen)
                            want = lsmc_pkg::STATUS_BYTES;
                        else
                            want = lsmc_pkg::STATUS_READY;
                        if (show && !(status_valid && want == status_shown))
                        begin
                            status_shown = want;
                            status_valid = 1'b1;
                            r.code       = want;
                            fire         = 1'b1;
                        end
                    end
                end
            endcase
        end
        if (fire)
            led_cmds_due.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= '0;
            items_taken <= 0;
            clear_led_state();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                derive_led_cmd(offered);
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_events.size() != 0
                    && (hold_cnt != 0 || $urandom_range(99) >= send_idle_pct))
                begin
                    offered  = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered.req;
                    s_tdata  <= {5'd0, offered.bytes_seen, offered.frames, offered.lost,
                                 offered.quality, offered.now};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // hold off the receiver for long stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt   <= 0;
            holds_done <= 0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else if ((holds_done == 0 && items_taken >= 300)
                 || (holds_done == 1 && items_taken >= 1000))
        begin
            hold_cnt   <= 150;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (led_cmds_due.size() == 0)
                begin
                    bad_transfers++;
                    if (bad_transfers <= 10)
                        $display("unexpected LED transfer: cmd %0d tdata %h",
                                 m_tuser, m_tdata);
                end
                else
                begin
                    head = led_cmds_due.pop_front();
                    if (m_tuser !== head.cmd || m_tdata[2:0] !== head.code
                        || m_tdata[10:3] !== head.quality)
                    begin
                        bad_transfers++;
                        if (bad_transfers <= 10)
                            $display({"LED transfer mismatch: expected cmd %0d code %0d ",
                                      "quality %0d, got cmd %0d code %0d quality %0d"},
                                     head.cmd, head.code, head.quality,
                                     m_tuser, m_tdata[2:0], m_tdata[10:3]);
                    end
                end
            end
            m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_event(input logic [lsmc_pkg::REQ_W-1:0] code,
                             input logic [lsmc_pkg::NOW_W-1:0] at,
                             input logic [lsmc_pkg::QUAL_W-1:0] q, input logic [2:0] fl);
        lsmc_pkg::item_t ev;
        ev = '{req: code, now: at, quality: q, lost: fl[2], frames: fl[1], bytes_seen: fl[0]};
        pending_events.push_back(ev);
        pushed_total++;
        if (code <= lsmc_pkg::REQ_UPDATE)
            useful_count++;
    endtask

    function automatic logic [lsmc_pkg::NOW_W-1:0] next_time();
        if ($urandom_range(39) == 0)
            ms_now = $urandom;
        else
            ms_now = ms_now + $urandom_range(0, step_max);
        return ms_now;
    endfunction

    function automatic logic [2:0] pick_flags();
        logic [2:0] fl;
        fl[2] = ($urandom_range(3) == 0);
        fl[1] = 1'($urandom_range(1));
        fl[0] = 1'($urandom_range(1));
        return fl;
    endfunction

    task automatic write_reg(input logic idx, input logic [lsmc_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == lsmc_pkg::CFG_DIAG_HOLD)
            hold_ms_reg = val;
        else
            blink_ms_reg = val;
    endtask

    task automatic wait_quiet();
        do @(posedge clk); while (items_taken != pushed_total || led_cmds_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_episodes(input int target);
        int         start_cnt;
        int         kind;
        int         pick;
        logic [2:0] fl;
        start_cnt = useful_count;
        fl = pick_flags();
        while (useful_count - start_cnt < target)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                repeat ($urandom_range(3, 10))
                begin
                    if ($urandom_range(3) == 0)
                        fl = pick_flags();
                    add_event(lsmc_pkg::REQ_UPDATE, next_time(), 8'($urandom), fl);
                end
            end
            else if (kind < 50)
            begin
                add_event($urandom_range(1) ? lsmc_pkg::REQ_LINK_QUAL
                                            : lsmc_pkg::REQ_DIAG_UNAVAIL,
                          next_time(), 8'($urandom), pick_flags());
                repeat ($urandom_range(2, 8))
                begin
                    if ($urandom_range(5) == 0)
                        fl = pick_flags();
                    add_event(lsmc_pkg::REQ_UPDATE, next_time(), 8'($urandom), fl);
                end
            end
            else if (kind < 75)
            begin
                pick = $urandom_range(3);
                add_event(pick == 0 ? lsmc_pkg::REQ_BIND
                                    : (pick == 1 ? lsmc_pkg::REQ_WIFI
                                                 : lsmc_pkg::REQ_MAINT_RESET),
                          next_time(), 8'($urandom), pick_flags());
                repeat ($urandom_range(3, 10))
                    add_event(lsmc_pkg::REQ_UPDATE, next_time(), 8'($urandom), pick_flags());
                if ($urandom_range(9) < 7)
                    add_event(lsmc_pkg::REQ_CLEAR_MAINT, next_time(), 8'($urandom),
                              pick_flags());
            end
            else if (kind < 83)
            begin
                add_event(lsmc_pkg::REQ_FATAL, next_time(), 8'($urandom), pick_flags());
                repeat ($urandom_range(0, 3))
                    add_event(4'($urandom_range(lsmc_pkg::REQ_LINK_QUAL,
                                                lsmc_pkg::REQ_UPDATE)),
                              next_time(), 8'($urandom), pick_flags());
                if ($urandom_range(1))
                    add_event(lsmc_pkg::REQ_FATAL, next_time(), 8'($urandom), pick_flags());
                if ($urandom_range(9) != 0)
                    add_event(lsmc_pkg::REQ_SOFT_RESET, next_time(), 8'($urandom),
                              pick_flags());
            end
            else if (kind < 90)
            begin
                add_event(lsmc_pkg::REQ_SOFT_RESET, next_time(), 8'($urandom), pick_flags());
                repeat ($urandom_range(2, 4))
                    add_event(lsmc_pkg::REQ_UPDATE, next_time(), 8'($urandom), fl);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    add_event(4'($urandom_range(0, REQ_CODES - 1)), $urandom, 8'($urandom),
                              pick_flags());
            end
        end
    endtask

    initial
    begin
        logic [lsmc_pkg::CFG_W-1:0] hold_set[6];
        logic [lsmc_pkg::CFG_W-1:0] blink_set[6];
        hold_set  = '{16'd0, 16'd65535, 16'd7, 16'd120, 16'd1, 16'd3000};
        blink_set = '{16'd0, 16'd65535, 16'd3, 16'd45, 16'd1, 16'd250};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(lsmc_pkg::CFG_DIAG_HOLD, lsmc_pkg::DIAG_HOLD_RESET);
        write_reg(lsmc_pkg::CFG_BLINK_PERIOD, lsmc_pkg::BLINK_PERIOD_RESET);
        send_idle_pct = 21;
        recv_idle_pct = 84;

        add_event(lsmc_pkg::REQ_UPDATE, 32'd100, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd101, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd102, 8'd0, 3'b100);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd103, 8'd0, 3'b011);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd104, 8'd0, 3'b001);
        add_event(lsmc_pkg::REQ_LINK_QUAL, 32'd1000, 8'hFF, 3'b111);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd3999, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd4000, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_LINK_QUAL, 32'd5000, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd5001, 8'd0, 3'b100);
        add_event(lsmc_pkg::REQ_DIAG_UNAVAIL, 32'hFFFF_FF00, 8'hA5, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'h0000_0A00, 8'd0, 3'b001);
        add_event(lsmc_pkg::REQ_UPDATE, 32'h0000_0BB8, 8'd0, 3'b001);
        add_event(lsmc_pkg::REQ_BIND, 32'hFFFF_FFFF, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_WIFI, 32'd9000, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_MAINT_RESET, 32'd9500, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd10000, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd10250, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd10499, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd10500, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_CLEAR_MAINT, 32'd10510, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_CLEAR_MAINT, 32'd10520, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd10600, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_FATAL, 32'd10700, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd10800, 8'd0, 3'b100);
        add_event(lsmc_pkg::REQ_FATAL, 32'd10900, 8'd0, 3'b000);
        add_event(4'(REQ_CODES - 1), 32'd11000, 8'd0, 3'b000);
        add_event(4'(lsmc_pkg::REQ_UPDATE + 1), 32'd11000, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_SOFT_RESET, 32'd11100, 8'd0, 3'b000);
        add_event(lsmc_pkg::REQ_UPDATE, 32'd0, 8'd0, 3'b000);
        wait_quiet();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(lsmc_pkg::CFG_DIAG_HOLD, hold_set[ph]);
            write_reg(lsmc_pkg::CFG_BLINK_PERIOD, blink_set[ph]);
            step_max = ((hold_set[ph] > blink_set[ph]) ? hold_set[ph] : blink_set[ph]) / 3 + 2;
            if (ph == 2)
                ms_now = 32'hFFFF_F000;
            if (ph == 2)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 21;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_episodes(180);
            wait_quiet();
        end

        if (bad_transfers == 0 && led_cmds_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
